/* design/lsfd_pkg.sv */
// ----------------------------------------------------------------------------
// lsfd_pkg
// Shared constants, types and the substitution ROM of the descrambler.
// ----------------------------------------------------------------------------
package lsfd_pkg;

	localparam logic [31:0] LcgMul    = 32'd1103515245;
	localparam logic [31:0] LcgInc    = 32'h0000_3039;
	localparam logic [31:0] SeedReset = 32'h5389_A4F8;

	localparam logic [2:0] CntReload = 3'd4;
	localparam logic [2:0] CntStart  = 3'd1;

	typedef logic [31:0] rom_words_t [64];

	localparam rom_words_t RomWords = '{
		32'h1E0D8064, 32'h16EFF6E2, 32'h3A29FF98, 32'hAD28CF5E, 32'hCEFC4584, 32'hACE3AB65,
		32'h924997EB, 32'hF7A813C3, 32'hDED07CDD, 32'hEC7278F8, 32'h2B9412A5, 32'h909A5339,
		32'h99AE3F04, 32'hC1BF7532, 32'hFEDB9102, 32'hF0B5D67D, 32'hB6B33C3D, 32'hA276BC00,
		32'h8550E19C, 32'h2D664A09, 32'h79D56AB7, 32'hD11B3EEA, 32'h95717BA3, 32'h8B87B259,
		32'h18819F5C, 32'h934BCB27, 32'hBD6B2A11, 32'h19F5C8A0, 32'h40C21FF2, 32'hDA03DF6C,
		32'h82B15521, 32'hE6778963, 32'h2473C9A9, 32'h37E4D9C6, 32'h68F44F17, 32'hAF8607C7,
		32'hDCB8A6FA, 32'h8E470A88, 32'h831A14E7, 32'h7F359E74, 32'hA1E052FD, 32'h330B4C41,
		32'hBBF38F44, 32'h0C7A5808, 32'h9BE53BF1, 32'hC05DD426, 32'h60A77EF9, 32'h342551E8,
		32'h5A4D0FD7, 32'hC41D36D3, 32'h62202F8A, 32'h8D61AAB0, 32'h4801698C, 32'h6ED8ED38,
		32'h2E05CC42, 32'h065B1022, 32'h0E46234E, 32'hEE5FE9BA, 32'hA430B4B9, 32'h571CBE54,
		32'h9D96FBCD, 32'h70C56731, 32'h566D4315, 32'hCA6FD22C
	};

	// control from the input stage to the state-holding units
	typedef struct packed {
		logic en;
		logic start;
	} step_t;

	// little-endian byte view of the word table
	function automatic logic [7:0] rom_byte(input logic [7:0] idx);
		logic [31:0] word;
		word = RomWords[idx[7:2]];
		return word[{idx[1:0], 3'b000} +: 8];
	endfunction

endpackage

/* design/lcg_sbox_feedback_descrambler.sv */
// ----------------------------------------------------------------------------
// lcg_sbox_feedback_descrambler
// Pipeline: input reg, then result reg.
// Throughput: one byte per cycle while m_axis_tready does not stall the output;
// the LCG multiply sits in the single stage between the two registers.
// Reset: asynchronous, seed 0x5389A4F8, keystream 0, counter 1, pipe empty.
// ----------------------------------------------------------------------------
module lcg_sbox_feedback_descrambler (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] cipher_byte
	input  logic        s_axis_tuser,  // [0] start_of_part
	input  logic        s_axis_tlast,  // end_of_part
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // [7:0] plain_byte
	output logic        m_axis_tlast,  // last_of_part
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);
	import lsfd_pkg::*;

	logic        valid_s1, valid_s2;
	logic [7:0]  cipher_s1, plain_s2;
	logic        start_s1, last_s1, last_s2;
	logic [31:0] seed_q;
	logic        adv_s1;
	logic [7:0]  key_byte, plain;
	step_t       step;

	assign cfg_ready     = 1'b1;
	assign adv_s1        = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv_s1;
	assign step          = {adv_s1, start_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= SeedReset;
		end else if (cfg_valid && cfg_ready) begin
			seed_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			cipher_s1 <= s_axis_tdata;
			start_s1  <= s_axis_tuser;
			last_s1   <= s_axis_tlast;
		end
	end

	lsfd_keystream u_keystream (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.seed     (seed_q),
		.key_byte (key_byte)
	);

	lsfd_sbox u_sbox (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.seed     (seed_q),
		.cipher   (cipher_s1),
		.key_byte (key_byte),
		.plain    (plain)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_axis_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			plain_s2 <= plain;
			last_s2  <= last_s1;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = plain_s2;
	assign m_axis_tlast  = last_s2;

endmodule

/* design/lsfd_keystream.sv */
// ----------------------------------------------------------------------------
// lsfd_keystream
// LCG state, keystream word and byte counter; gives the key byte of a step.
// ----------------------------------------------------------------------------
module lsfd_keystream (
	input  logic           clk,
	input  logic           arst_n,
	input  lsfd_pkg::step_t step,
	input  logic [31:0]    seed,
	output logic [7:0]     key_byte
);
	import lsfd_pkg::*;

	logic [31:0] lcg_q, ks_q;
	logic [2:0]  cnt_q;
	logic [31:0] lcg_cur, ks_cur, lcg_nxt, ks_nxt;
	logic [2:0]  cnt_cur, cnt_nxt;
	logic        adv;

	always_comb begin
		lcg_cur = step.start ? seed : lcg_q;
		ks_cur  = step.start ? 32'd0 : ks_q;
		cnt_cur = step.start ? CntStart : cnt_q;
		adv     = !(cnt_cur >= 3'd2 && cnt_cur <= CntReload);
		lcg_nxt = adv ? 32'(lcg_cur * LcgMul + LcgInc) : lcg_cur;
		ks_nxt  = adv ? lcg_nxt : (ks_cur >> 8);
		cnt_nxt = adv ? CntReload : 3'(cnt_cur - 3'd1);
	end

	assign key_byte = ks_nxt[7:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lcg_q <= SeedReset;
			ks_q  <= '0;
			cnt_q <= CntStart;
		end else if (step.en) begin
			lcg_q <= lcg_nxt;
			ks_q  <= ks_nxt;
			cnt_q <= cnt_nxt;
		end
	end

endmodule

/* design/lsfd_sbox.sv */
// ----------------------------------------------------------------------------
// lsfd_sbox
// Cipher feedback register and ROM substitution; forms the plain byte.
// ----------------------------------------------------------------------------
module lsfd_sbox (
	input  logic           clk,
	input  logic           arst_n,
	input  lsfd_pkg::step_t step,
	input  logic [31:0]    seed,
	input  logic [7:0]     cipher,
	input  logic [7:0]     key_byte,
	output logic [7:0]     plain
);
	import lsfd_pkg::*;

	logic [7:0] prev_q;
	logic [7:0] prev_cur;

	assign prev_cur = step.start ? ~seed[7:0] : prev_q;
	assign plain    = rom_byte(cipher ^ prev_cur) ^ key_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= ~SeedReset[7:0];
		end else if (step.en) begin
			prev_q <= cipher;
		end
	end

endmodule
